// ===== rtl/core/akf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// akf_pkg
// Shared types and constants for the abundant k-mer filter: chain depth,
// field widths, cell contents, chain commands and the controller states.
// ---------------------------------------------------------------------------
package akf_pkg;

    localparam int MAX_WORDS   = 64;
    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 7;
    localparam int THR_W       = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 2;

    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
    } cell_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_CLEAR
    } chain_op_t;

    typedef struct packed {
        cell_t head;
        logic  head_qual;
        logic  rest_qual;
        logic  any_eq;
        logic  full;
    } chain_status_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/core/abundant_kmer_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abundant_kmer_filter
// Counts distinct 64-bit k-mer words of a set and reports those whose count
// reaches min_count, in ascending order.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one word per transfer, s_tlast marks the last word of a set.
//   While loading, one word is taken every cycle; a sorted chain of
//   MAX_WORDS cells matches or inserts it in that same cycle.
//   After the last word the chain drains from its low end, one cell per
//   cycle unless a waiting result is stalled: a qualifying cell becomes a
//   result on the m_* channel, others are dropped. s_tready is low while
//   the chain drains. Results are registered: the emit state loads the head
//   cell into the result register that drives the m_* channel. m_tlast
//   marks the last result of the set; if nothing qualifies one empty result
//   (found = 0) is sent.
//   New words beyond MAX_WORDS distinct ones are dropped and flagged in
//   m_tuser[1] for every result of the set.
//   A stall on m_tready holds the result register and pauses the drain only
//   when a result (a qualifying word or the empty result) is waiting for it.
//   min_count is written through cfg_wr_en / cfg_wr_data while idle; the
//   user must keep to that, the block does not enforce it; zero acts as one.
//   Reset empties the chain, clears the flag and sets min_count to 1.
// ---------------------------------------------------------------------------
module abundant_kmer_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [akf_pkg::THR_W-1:0]       cfg_wr_data,   // min_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [akf_pkg::S_TDATA_W-1:0]   s_tdata,       // kmer[63:0]
    input  logic                            s_tlast,       // end_of_set
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [akf_pkg::M_TDATA_W-1:0]   m_tdata,       // abundant_kmer[63:0],
                                                           // occurrences[70:64], zero
    output logic [akf_pkg::M_TUSER_W-1:0]   m_tuser,       // found, overflowed
    output logic                            m_tlast        // final_result
);
    import akf_pkg::*;

    state_t             state_reg, state_next;
    logic [THR_W-1:0]   min_count_reg;
    logic [THR_W-1:0]   thr;
    logic               ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_found_reg, out_found_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    chain_op_t          op;
    chain_status_t      status;
    logic               in_xfer;
    logic               out_free;

    assign thr      = (min_count_reg == '0) ? {{(THR_W-1){1'b0}}, 1'b1} : min_count_reg;
    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    akf_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .ins_word (s_tdata[WORD_W-1:0]),
        .thr      (thr),
        .status   (status)
    );

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        op             = OP_HOLD;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_count_next = out_count_reg;
        out_found_next = out_found_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    op = OP_INSERT;
                    if (!status.any_eq && status.full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.head.valid && !status.head_qual)
                begin
                    op = OP_SHIFT;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ovf_next   = ovf_reg;
                    if (status.head.valid)
                    begin
                        out_word_next  = status.head.word;
                        out_count_next = status.head.count;
                        out_found_next = 1'b1;
                        out_last_next  = !status.rest_qual;
                    end
                    else
                    begin
                        // chain ran dry without a qualifying word
                        out_word_next  = '0;
                        out_count_next = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                    end
                    if (status.head.valid && status.rest_qual)
                    begin
                        op = OP_SHIFT;
                    end
                    else
                    begin
                        op         = OP_CLEAR;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            min_count_reg <= {{(THR_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                min_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_count_reg <= out_count_next;
        out_found_reg <= out_found_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_word_reg};
    assign m_tuser  = {out_ovf_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/akf_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// akf_cell
// One slot of the sorted chain: holds a word and its count, opens a gap for
// an incoming word, takes its left neighbor on insertion and its right
// neighbor while draining.
// ---------------------------------------------------------------------------
module akf_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  akf_pkg::chain_op_t             op,
    input  logic [akf_pkg::WORD_W-1:0]     ins_word,
    input  logic                           any_eq,
    input  logic                           full,
    input  logic [akf_pkg::THR_W-1:0]      thr,
    input  akf_pkg::cell_t                 prev,
    input  logic                           prev_lt,
    input  akf_pkg::cell_t                 next,
    output akf_pkg::cell_t                 cur,
    output logic                           lt,
    output logic                           eq,
    output logic                           qual
);
    import akf_pkg::*;

    logic               valid_reg, valid_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign lt   = valid_reg && (word_reg < ins_word);
    assign eq   = valid_reg && (word_reg == ins_word);
    assign qual = valid_reg && (count_reg >= thr);

    assign cur.valid = valid_reg;
    assign cur.word  = word_reg;
    assign cur.count = count_reg;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        count_next = count_reg;
        case (op)
            OP_INSERT:
            begin
                if (any_eq)
                begin
                    if (eq && count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (!full && !lt)
                begin
                    if (prev_lt)
                    begin
                        // the new word lands here, the rest moves right
                        valid_next = 1'b1;
                        word_next  = ins_word;
                        count_next = {{(COUNT_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        valid_next = prev.valid;
                        word_next  = prev.word;
                        count_next = prev.count;
                    end
                end
            end
            OP_SHIFT:
            begin
                valid_next = next.valid;
                word_next  = next.word;
                count_next = next.count;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        count_reg <= count_next;
    end

endmodule

// ===== rtl/core/akf_chain.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// akf_chain
// Row of sorted cells, ascending from cell 0, with the match and qualify
// reductions the controller needs.
// ---------------------------------------------------------------------------
module akf_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  akf_pkg::chain_op_t             op,
    input  logic [akf_pkg::WORD_W-1:0]     ins_word,
    input  logic [akf_pkg::THR_W-1:0]      thr,
    output akf_pkg::chain_status_t         status
);
    import akf_pkg::*;

    cell_t                cells [MAX_WORDS];
    logic [MAX_WORDS-1:0] lt_vec;
    logic [MAX_WORDS-1:0] eq_vec;
    logic [MAX_WORDS-1:0] qual_vec;
    logic                 any_eq;
    logic                 full;
    cell_t                empty_cell;

    assign empty_cell.valid = 1'b0;
    assign empty_cell.word  = '0;
    assign empty_cell.count = '0;

    assign any_eq = |eq_vec;
    assign full   = cells[MAX_WORDS-1].valid;

    genvar i;
    generate
        for (i = 0; i < MAX_WORDS; i++)
        begin : g_cell
            cell_t prev_c;
            cell_t next_c;
            logic  prev_lt_c;

            if (i == 0)
            begin : g_first
                assign prev_c    = empty_cell;
                assign prev_lt_c = 1'b1;
            end
            else
            begin : g_mid
                assign prev_c    = cells[i-1];
                assign prev_lt_c = lt_vec[i-1];
            end

            if (i == MAX_WORDS - 1)
            begin : g_last
                assign next_c = empty_cell;
            end
            else
            begin : g_inner
                assign next_c = cells[i+1];
            end

            akf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (op),
                .ins_word (ins_word),
                .any_eq   (any_eq),
                .full     (full),
                .thr      (thr),
                .prev     (prev_c),
                .prev_lt  (prev_lt_c),
                .next     (next_c),
                .cur      (cells[i]),
                .lt       (lt_vec[i]),
                .eq       (eq_vec[i]),
                .qual     (qual_vec[i])
            );
        end
    endgenerate

    assign status.head      = cells[0];
    assign status.head_qual = qual_vec[0];
    assign status.rest_qual = |qual_vec[MAX_WORDS-1:1];
    assign status.any_eq    = any_eq;
    assign status.full      = full;

endmodule

// ===== tb/tb_abundant_kmer_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_abundant_kmer_filter
// Self-checking bench for the abundant k-mer filter. A queue-fed driver
// streams k-mer sets into the block. A predictor keeps its own sorted tally
// of each set and queues the expected reports. A monitor compares every
// result transfer against them. The run steps through several thresholds
// and idle/stall profiles, and it includes overflow and count-saturation sets.
// ---------------------------------------------------------------------------
module tb_abundant_kmer_filter;

    import akf_pkg::*;

    localparam int TU_FOUND = 0;
    localparam int TU_OVF   = 1;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [WORD_W-1:0]  kmer;
        logic               last;
    } kmer_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  kmer;
        logic [COUNT_W-1:0] occ;
        logic               found;
        logic               ovf;
        logic               last;
    } kmer_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [THR_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;       // kmer[63:0]
    logic                   s_tlast = 1'b0;     // end_of_set
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;            // abundant_kmer[63:0], occurrences[70:64], zero
    logic [M_TUSER_W-1:0]   m_tuser;            // found, overflowed
    logic                   m_tlast;            // final_result

    abundant_kmer_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    kmer_item_t         word_feed[$];
    kmer_report_t       pending_reports[$];

    // predictor copy of the block state
    logic [WORD_W-1:0]  set_words[$];
    logic [COUNT_W-1:0] set_counts[$];
    logic               set_overflow = 1'b0;
    logic [THR_W-1:0]   thr_setting = 7'd1;

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 sets_done = 0;
    int                 reports_checked = 0;

    kmer_item_t         nxt_item;
    kmer_report_t       got_report;
    kmer_report_t       want_report;

    task automatic tally_word(input logic [WORD_W-1:0] w, input logic eos);
        int p;
        int last_q;
        int thr;
        kmer_report_t r;
        p = 0;
        while (p < set_words.size() && set_words[p] < w)
            p++;
        if (p < set_words.size() && set_words[p] == w)
        begin
            if (set_counts[p] != COUNT_MAX)
                set_counts[p] = set_counts[p] + 1'b1;
        end
        else if (set_words.size() >= MAX_WORDS)
            set_overflow = 1'b1;
        else
        begin
            set_words.insert(p, w);
            set_counts.insert(p, 7'd1);
        end
        if (eos)
        begin
            thr = (thr_setting == 0) ? 1 : int'(thr_setting);
            last_q = -1;
            foreach (set_counts[i])
                if (set_counts[i] >= thr)
                    last_q = i;
            if (last_q < 0)
            begin
                r.kmer  = '0;
                r.occ   = '0;
                r.found = 1'b0;
                r.ovf   = set_overflow;
                r.last  = 1'b1;
                pending_reports.insert(pending_reports.size(), r);
            end
            else
            begin
                foreach (set_counts[i])
                begin
                    if (set_counts[i] >= thr)
                    begin
                        r.kmer  = set_words[i];
                        r.occ   = set_counts[i];
                        r.found = 1'b1;
                        r.ovf   = set_overflow;
                        r.last  = (i == last_q);
                        pending_reports.insert(pending_reports.size(), r);
                    end
                end
            end
            set_words.delete();
            set_counts.delete();
            set_overflow = 1'b0;
            sets_done++;
        end
    endtask

    // input driver: valid only drops or changes after a transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tally_word(s_tdata, s_tlast);
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (word_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt_item = word_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt_item.kmer;
                    s_tlast  <= nxt_item.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_report.kmer  = m_tdata[WORD_W-1:0];
                got_report.occ   = m_tdata[WORD_W+COUNT_W-1:WORD_W];
                got_report.found = m_tuser[TU_FOUND];
                got_report.ovf   = m_tuser[TU_OVF];
                got_report.last  = m_tlast;
                reports_checked++;
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: kmer %h occ %0d found %b ovf %b last %b",
                                 got_report.kmer, got_report.occ, got_report.found,
                                 got_report.ovf, got_report.last);
                end
                else
                begin
                    want_report = pending_reports.pop_front();
                    if (got_report !== want_report
                        || m_tdata[M_TDATA_W-1:WORD_W+COUNT_W] !== '0)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("mismatch at %0t: expected kmer %h occ %0d found %b ovf %b last %b",
                                     $realtime, want_report.kmer, want_report.occ,
                                     want_report.found, want_report.ovf, want_report.last);
                            $display("                   actual kmer %h occ %0d found %b ovf %b last %b pad %h",
                                     got_report.kmer, got_report.occ, got_report.found,
                                     got_report.ovf, got_report.last,
                                     m_tdata[M_TDATA_W-1:WORD_W+COUNT_W]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_word(input logic [WORD_W-1:0] w, input logic eos);
        kmer_item_t it;
        it.kmer = w;
        it.last = eos;
        word_feed.insert(word_feed.size(), it);
    endtask

    // wait for all transfers and reports, then let the drain finish
    task automatic settle;
        int guard;
        guard = 0;
        while ((word_feed.size() != 0 || s_tvalid || pending_reports.size() != 0)
               && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (MAX_WORDS + 8) @(posedge clk);
    endtask

    task automatic write_min_count(input logic [THR_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thr_setting = v;
    endtask

    // short set drawn from a small pool so that words repeat
    task automatic queue_random_set(output int n);
        logic [WORD_W-1:0] pool[6];
        int k;
        foreach (pool[k2])
        begin
            k = $urandom_range(7);
            if (k == 0)
                pool[k2] = '0;
            else if (k == 1)
                pool[k2] = '1;
            else
                pool[k2] = {$urandom, $urandom};
        end
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++)
            push_word(pool[$urandom_range(5)], i == n - 1);
    endtask

    // more distinct words than the store holds, first word repeated once full
    task automatic queue_overflow_set;
        logic [WORD_W-1:0] first_w;
        logic [7:0]        tag;
        for (int i = 0; i < MAX_WORDS + 2; i++)
        begin
            tag = 8'(i);
            push_word({tag, 24'($urandom_range(24'hFFFFFF, 0)), $urandom}, 1'b0);
            if (i == 0)
                first_w = word_feed[word_feed.size() - 1].kmer;
        end
        push_word(first_w, 1'b0);
        push_word(first_w, 1'b0);
        push_word({8'hFF, 24'h0, $urandom}, 1'b0);
        push_word(first_w, 1'b1);
    endtask

    int unsigned idle_tbl[4]  = '{0, 66, 0, 38};
    int unsigned stall_tbl[4] = '{0, 0, 66, 38};
    int unsigned thr_tbl[4]   = '{1, 2, 3, 64};

    initial
    begin
        int rand_items;
        int n;
        logic [WORD_W-1:0] wa;
        logic [WORD_W-1:0] wb;
        logic [WORD_W-1:0] wc;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold of one, extremes of the word range
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_word(64'h0, 1'b0);
        push_word(64'h0, 1'b0);
        push_word(64'h5555_5555_5555_5555, 1'b0);
        push_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // single-word set
        push_word(64'h0123_4567_89AB_CDEF, 1'b1);
        settle();

        // threshold above every count gives the empty report
        write_min_count(7'd64);
        push_word(64'h1, 1'b0);
        push_word(64'h1, 1'b0);
        push_word(64'h2, 1'b1);
        settle();

        // zero acts as one
        write_min_count(7'd0);
        push_word(64'h8000_0000_0000_0000, 1'b0);
        push_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        settle();

        write_min_count(7'd127);
        push_word(64'hDEAD_BEEF_0000_0001, 1'b0);
        push_word(64'hDEAD_BEEF_0000_0001, 1'b1);
        settle();

        write_min_count(7'd2);
        wa = {$urandom, $urandom};
        wb = {$urandom, $urandom};
        wc = {$urandom, $urandom};
        push_word(wa, 1'b0);
        push_word(wb, 1'b0);
        push_word(wa, 1'b0);
        push_word(wc, 1'b0);
        push_word(wc, 1'b1);
        settle();

        rand_items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_tbl[ph];
            recv_stall_pct = stall_tbl[ph];
            write_min_count(THR_W'(thr_tbl[ph]));
            if (ph == 2)
                queue_overflow_set();
            if (ph == 3)
            begin
                // counts saturate well past the threshold
                wa = {$urandom, $urandom};
                for (int i = 0; i < 128; i++)
                    push_word(wa, i == 127);
                settle();
                write_min_count(7'd2);
            end
            while (rand_items < (ph + 1) * 12)
            begin
                queue_random_set(n);
                rand_items += n;
            end
            settle();
        end

        if (pending_reports.size() != 0)
            mismatches++;
        $display("run covered %0d sets, %0d words in, %0d results out", sets_done,
                 words_sent, reports_checked);
        $display("thresholds 0 to 127, store overflow, count saturation, idle and stall mixes");
        if (mismatches == 0)
            $display("tb_abundant_kmer_filter OK");
        else
            $display("tb_abundant_kmer_filter NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("tb_abundant_kmer_filter NOT OK");
        $finish;
    end

endmodule

// ===== abundant_kmer_filter.f =====
rtl/core/akf_pkg.sv
rtl/core/akf_cell.sv
rtl/core/akf_chain.sv
rtl/core/abundant_kmer_filter.sv
tb/tb_abundant_kmer_filter.sv
